// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL of the audio mixer.
// Standalone header; every macro takes a clock, a reset and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define MSAM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define MSAM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/msam_pkg.sv =====
// Shared types and constants of the multi-stream audio mixer.
// No dependencies; used by the top level.
package msam_pkg;

   // Field widths
   localparam int SAMPLE_W     = 16;
   localparam int GAIN_W       = 7;
   localparam int SESS_FIELD_W = 3;
   localparam int MODE_W       = 2;
   localparam int FRAME_W      = 2 * SAMPLE_W;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   // Scaling arithmetic, sized for the largest session count (64)
   localparam int FULL_SCALE_PCT = 100;
   localparam int ACC_W          = 23;   // signed mix accumulator
   localparam int MAG_W          = 22;   // operand magnitude
   localparam int PROD_W         = 28;   // magnitude times percent
   localparam int QUO_W          = 22;   // quotient by 100
   localparam int RECIP_SHIFT    = 28;
   localparam int MUL_B_W        = 22;
   localparam int MUL_P_W        = PROD_W + MUL_B_W;
   // floor(2^28 / 100); the quotient is short by at most one
   localparam logic [MUL_B_W-1:0] RECIP_K = 22'd2684354;

   localparam logic signed [ACC_W-1:0] SAMPLE_MAX = 23'sd32767;
   localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -23'sd32768;

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE   = 2'd0,
      MODE_MIX     = 2'd1,
      MODE_CONTROL = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MASTER_VOLUME = 1'd0,
      CSR_OUTPUT_MUTED  = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LOAD,
      ST_MASTER,
      ST_MUL,
      ST_RECIP,
      ST_FIX
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic [SESS_FIELD_W-1:0]   session;
      logic signed [SAMPLE_W-1:0] left_in;
      logic signed [SAMPLE_W-1:0] right_in;
      logic [GAIN_W-1:0]         volume;
      logic                      mute;
      logic                      enable;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       status;
   } rsp_payload_type;

endpackage

// ===== sv/msam_stream_if.sv =====
// Valid/ready channel carrying one request or one result per handshake.
// Payload type is a parameter; the mixer uses the structs of msam_pkg.
interface msam_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/multi_stream_audio_mixer.sv =====
// Multi-stream audio mixer: per-session frame rings, volume, mute and a saturating mix.
// Depends on msam_pkg, msam_stream_if, msam_ram and assert_macros.svh.
//
// Usage:
//   req_chan takes one request per handshake (valid and ready high at a clock edge):
//   write a frame to a session ring, set a session's control, or mix one frame.
//   rsp_chan returns exactly one result per request, in order.
//   csr_* writes master volume (index 0, clamped to 100) or output mute (index 1);
//   write it only while the block is idle.
// Sequencing:
//   Write, control, a mix while the output is muted and the unused mode give a
//   registered result in the cycle after acceptance. A mix scans the sessions in
//   turn, with a ring read and two scaling passes for each session that gives up
//   a frame, then two scaling passes for the master volume.
//   Every scaling pass runs on the single shared multiplier (multiply, reciprocal
//   multiply by 1/100, correct), so the multiplier sets the mix time.
//   A new request is taken only when the sequencer is idle.
// Reset (synchronous, active high) clears pointers, fill counts, mute and enable
// of every session, sets session volumes and master volume to 100. The ring
// memory is not cleared; no ring entry is read before it is written.
// A stalled receiver holds the result in the output register; the next request
// is taken in the same cycle as that result leaves.
`include "assert_macros.svh"

module multi_stream_audio_mixer #(
   parameter int SESSIONS    = 8,
   parameter int RING_FRAMES = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   msam_stream_if.sink                        req_chan,
   msam_stream_if.source                      rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [msam_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [msam_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import msam_pkg::*;

   localparam int SESS_W   = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
   localparam int PTR_W    = $clog2(RING_FRAMES);
   localparam int CNT_W    = $clog2(RING_FRAMES + 1);
   localparam int ADDR_W   = SESS_W + PTR_W;
   localparam int RAM_DEPTH = 2 ** ADDR_W;

   // ------------------------------------------------------------------
   // Helpers
   // ------------------------------------------------------------------
   function automatic logic [MAG_W-1:0] abs_mag(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] n;
      n = -v;
      return v[ACC_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
   endfunction

   function automatic logic signed [ACC_W-1:0] sext_sample(
      input logic [SAMPLE_W-1:0] s
   );
      return ACC_W'(signed'(s));
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] c;
      c = (v > SAMPLE_MAX) ? SAMPLE_MAX : ((v < SAMPLE_MIN) ? SAMPLE_MIN : v);
      return c[SAMPLE_W-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type                state_ff, state_in;
   logic [SESS_W-1:0]        sc_ff, sc_in;
   logic                     chan_ff, chan_in;      // 0 left, 1 right
   logic                     final_ff, final_in;    // master volume pass
   logic [FRAME_W-1:0]       frame_ff, frame_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [GAIN_W-1:0]        fac_ff, fac_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic signed [ACC_W-1:0]  acc_l_ff, acc_l_in;
   logic signed [ACC_W-1:0]  acc_r_ff, acc_r_in;
   logic signed [SAMPLE_W-1:0] mix_l_ff, mix_l_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_data_ff, rsp_data_in;
   logic [GAIN_W-1:0]        master_ff, master_in;
   logic                     out_muted_ff, out_muted_in;

   logic [PTR_W-1:0]         rp_ff [SESSIONS];
   logic [PTR_W-1:0]         rp_in [SESSIONS];
   logic [PTR_W-1:0]         wp_ff [SESSIONS];
   logic [PTR_W-1:0]         wp_in [SESSIONS];
   logic [CNT_W-1:0]         fill_ff [SESSIONS];
   logic [CNT_W-1:0]         fill_in [SESSIONS];
   logic [GAIN_W-1:0]        gain_ff [SESSIONS];
   logic [GAIN_W-1:0]        gain_in [SESSIONS];
   logic                     muted_ff [SESSIONS];
   logic                     muted_in [SESSIONS];
   logic                     enabled_ff [SESSIONS];
   logic                     enabled_in [SESSIONS];

   // ------------------------------------------------------------------
   // Request decode and per-session selection
   // ------------------------------------------------------------------
   logic              req_fire, req_sess_ok, last_sess;
   logic [SESS_W-1:0] sel_idx;
   logic [PTR_W-1:0]  rp_sel, wp_sel, rp_next, wp_next;
   logic [CNT_W-1:0]  fill_sel;
   logic              active_sel;
   logic              ring_wr_en, ring_rd_en, ctrl_en, mix_start;
   logic [FRAME_W-1:0] ram_rd_data;

   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_sess_ok    = 32'(req_chan.payload.session) < SESSIONS;
   assign last_sess      = sc_ff == SESS_W'(SESSIONS - 1);

   // One session is looked at per cycle: the request's when idle, else the scan's
   always_comb begin
      if (state_ff == ST_IDLE) begin
         sel_idx = req_sess_ok ? SESS_W'(req_chan.payload.session) : '0;
      end else begin
         sel_idx = sc_ff;
      end
   end

   assign rp_sel     = rp_ff[sel_idx];
   assign wp_sel     = wp_ff[sel_idx];
   assign fill_sel   = fill_ff[sel_idx];
   assign rp_next    = (rp_sel == PTR_W'(RING_FRAMES - 1)) ? '0 : rp_sel + PTR_W'(1);
   assign wp_next    = (wp_sel == PTR_W'(RING_FRAMES - 1)) ? '0 : wp_sel + PTR_W'(1);
   assign active_sel = enabled_ff[sel_idx] && !muted_ff[sel_idx] && (fill_sel != '0);

   assign ring_wr_en = req_fire && (req_chan.payload.mode == MODE_WRITE)
                       && req_sess_ok && enabled_ff[sel_idx];
   assign ctrl_en    = req_fire && (req_chan.payload.mode == MODE_CONTROL) && req_sess_ok;
   assign mix_start  = req_fire && (req_chan.payload.mode == MODE_MIX) && !out_muted_ff;
   assign ring_rd_en = (state_ff == ST_SCAN) && active_sel;

   // Frame ring store, one block of RING_FRAMES slots per session
   msam_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (RAM_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr ({sel_idx, wp_sel}),
      .wr_data ({req_chan.payload.right_in, req_chan.payload.left_in}),
      .rd_en   (ring_rd_en),
      .rd_addr ({sel_idx, rp_sel}),
      .rd_data (ram_rd_data)
   );

   // Per-session state updates
   always_comb begin
      rp_in      = rp_ff;
      wp_in      = wp_ff;
      fill_in    = fill_ff;
      gain_in    = gain_ff;
      muted_in   = muted_ff;
      enabled_in = enabled_ff;
      if (ring_wr_en) begin
         wp_in[sel_idx] = wp_next;
         if (fill_sel != CNT_W'(RING_FRAMES)) begin
            fill_in[sel_idx] = fill_sel + CNT_W'(1);
         end
      end
      if (ctrl_en) begin
         gain_in[sel_idx]  = (req_chan.payload.volume > GAIN_W'(FULL_SCALE_PCT)) ?
                             GAIN_W'(FULL_SCALE_PCT) : req_chan.payload.volume;
         muted_in[sel_idx] = req_chan.payload.mute;
         // enabling clears the ring
         if (req_chan.payload.enable && !enabled_ff[sel_idx]) begin
            rp_in[sel_idx]   = '0;
            wp_in[sel_idx]   = '0;
            fill_in[sel_idx] = '0;
         end
         enabled_in[sel_idx] = req_chan.payload.enable;
      end
      if (ring_rd_en) begin
         rp_in[sel_idx]   = rp_next;
         fill_in[sel_idx] = fill_sel - CNT_W'(1);
      end
   end

   // ------------------------------------------------------------------
   // Shared multiplier and divide-by-100 correction
   // ------------------------------------------------------------------
   logic [PROD_W-1:0]       mul_a;
   logic [MUL_B_W-1:0]      mul_b;
   logic [MUL_P_W-1:0]      mul_p;
   logic [PROD_W-1:0]       fix_q100, fix_rem;
   logic [QUO_W-1:0]        fix_quo;
   logic signed [ACC_W-1:0] fix_pos, fix_val;

   assign mul_a = (state_ff == ST_RECIP) ? prod_ff : PROD_W'(mag_ff);
   assign mul_b = (state_ff == ST_RECIP) ? RECIP_K : MUL_B_W'(fac_ff);
   assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   // 100 * q as 64q + 32q + 4q, then one step of correction
   assign fix_q100 = (PROD_W'(quo_ff) << 6) + (PROD_W'(quo_ff) << 5)
                     + (PROD_W'(quo_ff) << 2);
   assign fix_rem  = prod_ff - fix_q100;
   assign fix_quo  = (fix_rem >= PROD_W'(FULL_SCALE_PCT)) ? quo_ff + QUO_W'(1) : quo_ff;
   assign fix_pos  = signed'(ACC_W'(fix_quo));
   assign fix_val  = neg_ff ? -fix_pos : fix_pos;

   // ------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (mix_start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (active_sel)     state_in = ST_LOAD;
            else if (last_sess) state_in = ST_MASTER;
         end
         ST_LOAD:   state_in = ST_MUL;
         ST_MASTER: state_in = ST_MUL;
         ST_MUL:    state_in = ST_RECIP;
         ST_RECIP:  state_in = ST_FIX;
         ST_FIX: begin
            if (!chan_ff)       state_in = ST_MUL;
            else if (final_ff)  state_in = ST_IDLE;
            else if (last_sess) state_in = ST_MASTER;
            else                state_in = ST_SCAN;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer: datapath and result
   // ------------------------------------------------------------------
   always_comb begin
      sc_in        = sc_ff;
      chan_in      = chan_ff;
      final_in     = final_ff;
      frame_in     = frame_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      fac_in       = fac_ff;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      acc_l_in     = acc_l_ff;
      acc_r_in     = acc_r_ff;
      mix_l_in     = mix_l_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_chan.ready ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (mix_start) begin
               sc_in    = '0;
               final_in = 1'b0;
               acc_l_in = '0;
               acc_r_in = '0;
            end else if (req_fire) begin
               // immediate result: write, control, muted mix or unused mode
               rsp_valid_in          = 1'b1;
               rsp_data_in.left_out  = '0;
               rsp_data_in.right_out = '0;
               rsp_data_in.status    = (req_chan.payload.mode == MODE_WRITE) && !ring_wr_en;
            end
         end
         ST_SCAN: begin
            chan_in = 1'b0;
            if (!active_sel && !last_sess) sc_in = sc_ff + SESS_W'(1);
         end
         ST_LOAD: begin
            frame_in = ram_rd_data;
            mag_in   = abs_mag(sext_sample(ram_rd_data[SAMPLE_W-1:0]));
            neg_in   = ram_rd_data[SAMPLE_W-1];
            fac_in   = gain_ff[sel_idx];
         end
         ST_MASTER: begin
            chan_in  = 1'b0;
            final_in = 1'b1;
            mag_in   = abs_mag(acc_l_ff);
            neg_in   = acc_l_ff[ACC_W-1];
            fac_in   = master_ff;
         end
         ST_MUL: begin
            prod_in = mul_p[PROD_W-1:0];
         end
         ST_RECIP: begin
            quo_in = mul_p[RECIP_SHIFT +: QUO_W];
         end
         ST_FIX: begin
            if (!chan_ff) begin
               // left done, set up the right channel
               chan_in = 1'b1;
               if (final_ff) begin
                  mix_l_in = sat16(fix_val);
                  mag_in   = abs_mag(acc_r_ff);
                  neg_in   = acc_r_ff[ACC_W-1];
               end else begin
                  acc_l_in = acc_l_ff + fix_val;
                  mag_in   = abs_mag(sext_sample(frame_ff[FRAME_W-1:SAMPLE_W]));
                  neg_in   = frame_ff[FRAME_W-1];
               end
            end else if (final_ff) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.left_out  = mix_l_ff;
               rsp_data_in.right_out = sat16(fix_val);
               rsp_data_in.status    = 1'b0;
            end else begin
               acc_r_in = acc_r_ff + fix_val;
               if (!last_sess) sc_in = sc_ff + SESS_W'(1);
            end
         end
         default: begin
            chan_in = 1'b0;
         end
      endcase
   end

   // Configuration registers
   always_comb begin
      master_in    = master_ff;
      out_muted_in = out_muted_ff;
      if (csr_write_enable && (csr_index == CSR_MASTER_VOLUME)) begin
         master_in = (csr_write_data > GAIN_W'(FULL_SCALE_PCT)) ?
                     GAIN_W'(FULL_SCALE_PCT) : csr_write_data;
      end
      if (csr_write_enable && (csr_index == CSR_OUTPUT_MUTED)) begin
         out_muted_in = csr_write_data[0];
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // ------------------------------------------------------------------
   // Flops
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sc_ff        <= '0;
         chan_ff      <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         master_ff    <= GAIN_W'(FULL_SCALE_PCT);
         out_muted_ff <= 1'b0;
         for (int i = 0; i < SESSIONS; i++) begin
            rp_ff[i]      <= '0;
            wp_ff[i]      <= '0;
            fill_ff[i]    <= '0;
            gain_ff[i]    <= GAIN_W'(FULL_SCALE_PCT);
            muted_ff[i]   <= 1'b0;
            enabled_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         sc_ff        <= sc_in;
         chan_ff      <= chan_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
         master_ff    <= master_in;
         out_muted_ff <= out_muted_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         gain_ff      <= gain_in;
         muted_ff     <= muted_in;
         enabled_ff   <= enabled_in;
      end
   end

   // Datapath, no reset
   always_ff @(posedge clock) begin
      frame_ff    <= frame_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      fac_ff      <= fac_in;
      prod_ff     <= prod_in;
      quo_ff      <= quo_in;
      acc_l_ff    <= acc_l_in;
      acc_r_ff    <= acc_r_in;
      mix_l_ff    <= mix_l_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // output slot must be free when a mix completes
   `MSAM_ASSERT_IMP(a_mix_slot_free, clock, reset,
      (state_ff == ST_FIX) && final_ff && chan_ff, !rsp_valid_ff,
      "mix finished while a result was still pending")
   // reciprocal quotient is short by at most one
   `MSAM_ASSERT_IMP(a_recip_bound, clock, reset,
      state_ff == ST_FIX, fix_rem < PROD_W'(2 * FULL_SCALE_PCT),
      "divide-by-100 correction out of range")
   // a ring read is followed by the load step
   `MSAM_ASSERT_NEXT(a_read_then_load, clock, reset,
      ring_rd_en, state_ff == ST_LOAD,
      "ring read not followed by frame load")
   // scan index stays within the session count
   `MSAM_ASSERT_IMP(a_scan_range, clock, reset,
      state_ff != ST_IDLE, 32'(sc_ff) < SESSIONS,
      "session scan index out of range")

endmodule

// ===== sv/msam_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
module msam_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
